// ===== sv/sphere_frustum_cull_classify_defines.svh =====
// assertion macros for the cull classifier checker
`ifndef SPHERE_FRUSTUM_CULL_CLASSIFY_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_CLASSIFY_DEFINES_SVH
// implication checked on every clock, off during reset
`define SFC_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// next-cycle implication, off during reset
`define SFC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

// ===== sv/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// shared widths and types for the sphere frustum cull classifier
// ----------------------------------------------------------------------------
package sfc_pkg;
  localparam int NumPlanes = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int InDataW = 304; // tdata fields fill whole bytes exactly
  localparam int InUserW = 1;
  localparam int OutDataW = 16;
  localparam int OutUserW = 2;
  localparam int SqW = 34;      // squared column length
  localparam int ScaleW = 17;   // floor sqrt of squared length
  localparam int WcW = 36;      // world centre, Q.18
  localparam int DistW = 56;    // plane distance, Q.32

  typedef enum logic [1:0] {
    BUCKET_CULLED = 2'd0,
    BUCKET_OPAQUE = 2'd1,
    BUCKET_BLEND  = 2'd2
  } bucket_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEFT = 3'd0, REG_RIGHT = 3'd1, REG_BOTTOM = 3'd2,
    REG_TOP = 3'd3, REG_NEAR = 3'd4, REG_FAR = 3'd5
  } reg_idx_t;

  // side-band that travels with a word down the pipe
  typedef struct packed {
    logic [15:0] tag;
    logic        blend;
    logic        empty;
  } side_t;
endpackage

// ===== sv/sfc_isqrt.sv =====
// ----------------------------------------------------------------------------
// sfc_isqrt
// pipelined floor square root, two result bits per stage (one in the first), stallable
// ----------------------------------------------------------------------------
module sfc_isqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sfc_pkg::SqW-1:0]   x,
  output logic [sfc_pkg::ScaleW-1:0] root
);
  import sfc_pkg::*;
  localparam int Stages = 9;        // 17 result bits, one in stage 0, two in each later stage
  localparam int RemW = SqW + 2;

  logic [SqW-1:0]    xs  [Stages];
  logic [RemW-1:0]   rem [Stages];
  logic [ScaleW-1:0] res [Stages];

  // stage k decides result bits from the top down
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Stages; k++) begin
        logic [SqW-1:0]    xin;
        logic [RemW-1:0]   rin;
        logic [ScaleW-1:0] qin;
        logic [RemW-1:0]   r;
        logic [ScaleW-1:0] q;
        logic [RemW-1:0]   t;
        if (k == 0) begin
          xin = x; rin = '0; qin = '0;
        end else begin
          xin = xs[k-1]; rin = rem[k-1]; qin = res[k-1];
        end
        r = rin; q = qin;
        for (int s = 0; s < 2; s++) begin
          int bi;
          bi = 2 * (Stages - 1 - k) + 1 - s;
          if (bi < ScaleW) begin
            r = {r[RemW-3:0], xin[2*bi+1 -: 2]};
            t = {{(RemW-ScaleW-2){1'b0}}, q, 2'b01};
            if (r >= t) begin
              r = r - t;
              q = {q[ScaleW-2:0], 1'b1};
            end else begin
              q = {q[ScaleW-2:0], 1'b0};
            end
          end
        end
        xs[k] <= xin; rem[k] <= r; res[k] <= q;
      end
    end
  end
  assign root = res[Stages-1];
endmodule

// ===== sv/sphere_frustum_cull_classify.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull_classify
// bounding sphere against six frustum planes, bucketed draw classification
// ----------------------------------------------------------------------------
// usage:
//   planes are written through cfg_we / cfg_index / cfg_data (index 0..5,
//   left, right, bottom, top, near, far); other indexes are ignored.
//   one object word enters on s_axis per cycle while the pipe advances;
//   s_axis_tuser carries blend. m_axis_tdata carries tag, m_axis_tuser bucket.
// throughput: one word per cycle unless stalled, fully pipelined datapath.
// depth: the output register follows the nine-stage square root, which
//   runs beside the plane dot products and the distance delay line.
// stall: the whole pipe advances only when the output register is empty or
//   taken, so a stalled receiver holds every word in place, none lost.
// reset: clears all valid bits and the six planes to zero.
module sphere_frustum_cull_classify (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sfc_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // basis_col_x, basis_col_y, basis_col_z, translation, sphere_center,
  // sphere_radius, index_total, object_tag
  input  logic [sfc_pkg::InDataW-1:0]      s_axis_tdata,
  // blend_mode
  input  logic [sfc_pkg::InUserW-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tag_out
  output logic [sfc_pkg::OutDataW-1:0]     m_axis_tdata,
  // bucket
  output logic [sfc_pkg::OutUserW-1:0]     m_axis_tuser
);
  import sfc_pkg::*;
  localparam int Lat = 13;
  localparam int SqDelay = 9;

  logic [CfgDataW-1:0] planes [NumPlanes];
  logic [Lat-1:0] vld;
  logic en;

  assign en = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumPlanes; i++) planes[i] <= '0;
    end else if (cfg_we && cfg_index < CfgIdxW'(NumPlanes)) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  // unpack
  logic signed [15:0] b_in [3][3];
  logic signed [15:0] t_in [3];
  logic signed [15:0] c_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) b_in[i][j] = s_axis_tdata[48*i + 16*j +: 16];
      t_in[i] = s_axis_tdata[144 + 16*i +: 16];
      c_in[i] = s_axis_tdata[192 + 16*i +: 16];
    end
  end

  // s1: products
  logic signed [31:0] bc1 [3][3];
  logic signed [31:0] sq1 [3][3];
  logic signed [15:0] t1 [3];
  logic [15:0] rad1;
  side_t side [Lat-1];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          bc1[i][j] <= b_in[i][j] * c_in[i];
          sq1[i][j] <= b_in[i][j] * b_in[i][j];
        end
        t1[i] <= t_in[i];
      end
      rad1 <= s_axis_tdata[240 +: 16];
      side[0] <= '{tag: s_axis_tdata[288 +: 16], blend: s_axis_tuser[0],
                   empty: (s_axis_tdata[256 +: 32] == '0)};
      for (int k = 1; k < Lat-1; k++) side[k] <= side[k-1];
    end
  end

  // s2: world centre (y and z flipped), column squared lengths
  logic signed [WcW-1:0] w2 [3];
  logic [SqW-1:0] csq2 [3];
  logic [15:0] rad2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [WcW-1:0] acc;
        acc = (WcW'(t1[j]) <<< 12) + WcW'(bc1[0][j]) + WcW'(bc1[1][j])
              + WcW'(bc1[2][j]);
        w2[j] <= (j == 0) ? acc : -acc;
      end
      for (int i = 0; i < 3; i++)
        csq2[i] <= SqW'(unsigned'(sq1[i][0])) + SqW'(unsigned'(sq1[i][1]))
                   + SqW'(unsigned'(sq1[i][2]));
      rad2 <= rad1;
    end
  end

  // s3: largest squared length
  logic [SqW-1:0] max3;
  logic [15:0] rad3;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [SqW-1:0] m;
      m = (csq2[0] > csq2[1]) ? csq2[0] : csq2[1];
      max3 <= (csq2[2] > m) ? csq2[2] : m;
      rad3 <= rad2;
    end
  end

  // plane products, then distance, then delay to meet the root
  logic signed [WcW+16-1:0] pp3 [NumPlanes][3];
  logic signed [DistW-1:0] dist4 [NumPlanes];
  logic signed [DistW-1:0] dly [SqDelay-1][NumPlanes];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NumPlanes; p++) begin
        for (int j = 0; j < 3; j++)
          pp3[p][j] <= $signed(planes[p][16*j +: 16]) * w2[j];
        dist4[p] <= (DistW'($signed(planes[p][48 +: 16])) <<< 26)
                    + DistW'(pp3[p][0]) + DistW'(pp3[p][1]) + DistW'(pp3[p][2]);
        dly[0][p] <= dist4[p];
        for (int k = 1; k < SqDelay-1; k++) dly[k][p] <= dly[k-1][p];
      end
    end
  end

  // radius delay beside the square root
  logic [15:0] rdl [SqDelay];
  logic [ScaleW-1:0] scale12;
  always_ff @(posedge clk) begin
    if (en) begin
      rdl[0] <= rad3;
      for (int k = 1; k < SqDelay; k++) rdl[k] <= rdl[k-1];
    end
  end
  sfc_isqrt u_sqrt (.clk(clk), .en(en), .x(max3), .root(scale12));

  // s13: world radius and compare, into output register
  logic [32:0] wrad;
  logic vis;
  logic [1:0] bkt;
  always_comb begin
    wrad = 33'(rdl[SqDelay-1]) * 33'(scale12);
    vis = 1'b1;
    for (int p = 0; p < NumPlanes; p++)
      if (dly[SqDelay-2][p] < -(DistW'(signed'({1'b0, wrad})) <<< 14)) vis = 1'b0;
    if (side[Lat-2].empty || !vis) bkt = BUCKET_CULLED;
    else bkt = side[Lat-2].blend ? BUCKET_BLEND : BUCKET_OPAQUE;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= side[Lat-2].tag;
      m_axis_tuser <= bkt;
    end
  end
  assign m_axis_tvalid = vld[Lat-1];
endmodule

// ===== sv/sfc_checker.sv =====
// ----------------------------------------------------------------------------
// sfc_checker
// port-level checks on the cull classifier
// ----------------------------------------------------------------------------
`include "sphere_frustum_cull_classify_defines.svh"
module sfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser
);
  // bucket codes stay in range
  `SFC_ASSERT_IMPL(a_bucket, clk, rst, m_axis_tvalid, m_axis_tuser != 2'd3)
  // a stalled output holds
  `SFC_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // the input side waits only while the output is stalled
  `SFC_ASSERT_IMPL(a_ready, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
endmodule

bind sphere_frustum_cull_classify sfc_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tuser(m_axis_tuser)
);

// ===== test/tb_sphere_frustum_cull_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_frustum_cull_classify
// streams objects through the cull classifier and checks every tag and
// bucket against a bit-exact fixed-point prediction, across plane settings
// ----------------------------------------------------------------------------
module tb_sphere_frustum_cull_classify;
  import sfc_pkg::*;

  typedef struct {
    logic [47:0] col_x, col_y, col_z, trans, center;
    logic [15:0] radius;
    logic [31:0] idx_total;
    logic        blend;
    logic [15:0] tag;
  } object_t;

  typedef struct {
    logic [15:0] tag;
    bucket_t     bkt;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  sphere_frustum_cull_classify dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  logic [63:0] planes [NumPlanes];
  object_t  pending_objs [$];
  verdict_t verdicts [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;        // no random idling on either side
  int hold_off = 0;    // receiver stall cycles left
  bit stall_req = 0;   // starts a long receiver stall
  bit sender_pause = 0;

  function automatic longint lane(logic [63:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 32;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // bit-exact classification of one object against current planes
  function automatic verdict_t classify(object_t o);
    verdict_t v;
    logic [63:0] cols [3];
    longint cen [3], wc [3], acc, pdist, wrad32;
    longint unsigned sq, maxsq;
    bit seen;
    cols[0] = o.col_x; cols[1] = o.col_y; cols[2] = o.col_z;
    maxsq = 0;
    for (int i = 0; i < 3; i++) begin
      sq = 0;
      for (int j = 0; j < 3; j++) sq += lane(cols[i], j) * lane(cols[i], j);
      if (sq > maxsq) maxsq = sq;
      cen[i] = lane(o.center, i);
    end
    for (int j = 0; j < 3; j++) begin
      acc = lane(o.trans, j) * 4096;
      for (int i = 0; i < 3; i++) acc += lane(cols[i], j) * cen[i];
      wc[j] = (j == 0) ? acc : -acc;
    end
    wrad32 = longint'(o.radius) * longint'(root_floor(maxsq)) * 16384;
    seen = 1;
    for (int p = 0; p < NumPlanes; p++) begin
      pdist = lane(planes[p], 3) * (64'sd1 <<< 26);
      for (int j = 0; j < 3; j++) pdist += lane(planes[p], j) * wc[j];
      if (pdist < -wrad32) seen = 0;
    end
    v.tag = o.tag;
    if (o.idx_total == 0 || !seen) v.bkt = BUCKET_CULLED;
    else v.bkt = o.blend ? BUCKET_BLEND : BUCKET_OPAQUE;
    return v;
  endfunction

  // accept seen at the last rising edge
  logic s_axis_tready_q = 1'b0;
  always @(posedge clk) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

  // driver: offers words at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_objs.size() > 0 && !sender_pause &&
            (calm || $urandom_range(99) >= 16)) begin
          object_t o;
          o = pending_objs.pop_front();
          s_axis_tdata <= {o.tag, o.idx_total, o.radius, o.center, o.trans,
                           o.col_z, o.col_y, o.col_x};
          s_axis_tuser <= o.blend;
          s_axis_tvalid <= 1'b1;
          verdicts.insert(verdicts.size(), classify(o));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready at the falling edge, with one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_req) begin
        hold_off <= 300;
        m_axis_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(99) >= 16;
      end
    end
  end

  // monitor: checks words at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts.size() == 0) begin
        $error("unexpected word tag %h", m_axis_tdata);
        errors = errors + 1;
      end else begin
        verdict_t e;
        e = verdicts.pop_front();
        if (m_axis_tdata !== e.tag) begin
          $error("tag_out expected %h actual %h", e.tag, m_axis_tdata);
          errors = errors + 1;
        end
        if (m_axis_tuser !== e.bkt) begin
          $error("bucket expected %0d actual %0d", e.bkt, m_axis_tuser);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("[sphere_frustum_cull_classify] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] rnd_q(int mag);
    return 16'($signed($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic object_t rand_obj(bit wild);
    object_t o;
    if (wild) begin
      o.col_x = 48'({$urandom, $urandom}); o.col_y = 48'({$urandom, $urandom});
      o.col_z = 48'({$urandom, $urandom}); o.trans = 48'({$urandom, $urandom});
      o.center = 48'({$urandom, $urandom}); o.radius = 16'($urandom);
      o.idx_total = $urandom;
    end else begin
      // plausible transforms near the frustum
      o.col_x = {rnd_q(8192), rnd_q(8192), rnd_q(8192)};
      o.col_y = {rnd_q(8192), rnd_q(8192), rnd_q(8192)};
      o.col_z = {rnd_q(8192), rnd_q(8192), rnd_q(8192)};
      o.trans = {rnd_q(3000), rnd_q(3000), rnd_q(3000)};
      o.center = {rnd_q(500), rnd_q(500), rnd_q(500)};
      o.radius = 16'($urandom_range(1000));
      o.idx_total = ($urandom_range(9) == 0) ? 0 : $urandom;
    end
    o.blend = 1'($urandom);
    o.tag = 16'($urandom);
    return o;
  endfunction

  function automatic logic [63:0] rand_plane(bit wild);
    if (wild) return {$urandom, $urandom};
    return {rnd_q(2000), rnd_q(16384), rnd_q(16384), rnd_q(16384)};
  endfunction

  task automatic queue_obj(object_t o);
    pending_objs.insert(pending_objs.size(), o);
  endtask

  task automatic drain();
    while (pending_objs.size() > 0 || verdicts.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_plane(logic [CfgIdxW-1:0] i, logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= i; cfg_data <= v;
    if (i < NumPlanes) planes[i] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    object_t o;
    for (int p = 0; p < NumPlanes; p++) planes[p] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: zero planes never cull, empty objects, extremes
    o = rand_obj(0);
    o.idx_total = 0; queue_obj(o);
    o.idx_total = 1; o.blend = 0; queue_obj(o);
    o.blend = 1; queue_obj(o);
    o.col_x = '1; o.col_y = '1; o.col_z = '1; o.trans = '1; o.center = '1;
    o.radius = '1; o.idx_total = '1; o.tag = '1; queue_obj(o);
    o.col_x = {3{16'h8000}}; o.col_y = {3{16'h8000}}; o.col_z = {3{16'h8000}};
    o.trans = {3{16'h8000}}; o.center = {3{16'h7fff}}; o.radius = 0; o.tag = 0;
    queue_obj(o);
    drain();

    // single plane x >= 0 at origin; boundary case with unit transform
    write_plane(REG_LEFT, {16'd0, 16'd0, 16'd0, 16'sd16384});
    write_plane(3'd6, '1);   // ignored index
    write_plane(3'd7, '1);
    o = rand_obj(0);
    o.col_x = {16'd0, 16'd0, 16'd4096}; o.col_y = {16'd0, 16'd4096, 16'd0};
    o.col_z = {16'd4096, 16'd0, 16'd0}; o.trans = '0; o.idx_total = 5;
    o.radius = 64; o.center = {16'd0, 16'd0, -16'sd64}; queue_obj(o);
    o.center = {16'd0, 16'd0, -16'sd65}; queue_obj(o);
    o.center = {16'd0, 16'd0, 16'sd100}; queue_obj(o);
    drain();

    // random phases over several plane settings
    for (int ph = 0; ph < 7; ph++) begin
      for (int p = 0; p < NumPlanes; p++) begin
        case (ph)
          0: write_plane(CfgIdxW'(p), '1);
          1: write_plane(CfgIdxW'(p), {4{16'h8000}});
          2: write_plane(CfgIdxW'(p), {4{16'h7fff}});
          3, 4: write_plane(CfgIdxW'(p), rand_plane(1));
          default: write_plane(CfgIdxW'(p), (p < 4) ? rand_plane(0) : 64'd0);
        endcase
      end
      calm = (ph == 2);
      for (int k = 0; k < 200; k++) queue_obj(rand_obj($urandom_range(4) == 0));
      if (ph == 3) begin
        // long receiver stall while the sender keeps offering
        @(negedge clk) stall_req <= 1'b1;
        @(negedge clk) stall_req <= 1'b0;
      end
      if (ph == 5) begin
        while (pending_objs.size() > 100) @(posedge clk);
        sender_pause = 1;
        while (verdicts.size() > 0) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[sphere_frustum_cull_classify] OK");
    end else begin
      $display("[sphere_frustum_cull_classify] ERROR");
    end
    $finish;
  end
endmodule
